// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CCAP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ccap: immediate property failed");
`define CCAP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ccap: next-cycle property failed");
`else
`define CCAP_ASSERT(label, clk, rst_n, prop)
`define CCAP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/ccap_pkg.sv =====
// ---------------------------------------------------------------------------
// ccap_pkg
// Types, register map, op codes and the per-stage colour adjustment.
// ---------------------------------------------------------------------------
`default_nettype none
package ccap_pkg;

  localparam int unsigned NUM_OPS       = 6;   // op registers in the map
  localparam int unsigned STAGES_DEF    = 6;
  localparam int unsigned QDEPTH        = 4;   // front/back queue entries
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 8;
  localparam int unsigned PIX_W         = 24;

  localparam logic [CFG_IDX_W-1:0] REG_MIDPOINT = 3'd6;
  localparam logic [7:0]           MIDPOINT_RST = 8'd128;

  typedef enum logic [3:0] {
    OP_IDENT    = 4'd0,
    OP_BRIGHT_U = 4'd1,
    OP_BRIGHT_D = 4'd2,
    OP_CONTR_U  = 4'd3,
    OP_CONTR_D  = 4'd4,
    OP_INVERT   = 4'd5,
    OP_SEPIA    = 4'd6,
    OP_GRAY     = 4'd7,
    OP_R_UP     = 4'd8,
    OP_G_UP     = 4'd9,
    OP_B_UP     = 4'd10,
    OP_R_DN     = 4'd11,
    OP_G_DN     = 4'd12,
    OP_B_DN     = 4'd13
  } op_t;

  // red in the low byte
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  function automatic logic [7:0] sat_add(logic [7:0] v, logic [3:0] d);
    logic [8:0] s;
    s = {1'b0, v} + {5'b0, d};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  function automatic logic [7:0] sat_sub(logic [7:0] v, logic [3:0] d);
    return (v > {4'b0, d}) ? (v - {4'b0, d}) : 8'h00;
  endfunction

  // floor(v/15) for 8-bit v: v*137 >> 11 is exact over 0..255
  function automatic logic [7:0] div15(logic [7:0] v);
    logic [15:0] p;
    p = {8'b0, v} * 16'd137;
    return {3'b000, p[15:11]};
  endfunction

  function automatic logic [7:0] contrast(logic [7:0] v, logic [7:0] mid, logic up);
    logic bright;
    bright = (v >= mid);
    return (bright == up) ? sat_add(v, 4'd5) : sat_sub(v, 4'd5);
  endfunction

  function automatic pixel_t apply_op(op_t op, logic [7:0] mid, pixel_t p);
    pixel_t r;
    r = p;
    case (op)
      OP_BRIGHT_U: begin
        r.red   = sat_add(p.red, 4'd10);
        r.green = sat_add(p.green, 4'd10);
        r.blue  = sat_add(p.blue, 4'd10);
      end
      OP_BRIGHT_D: begin
        r.red   = sat_sub(p.red, 4'd10);
        r.green = sat_sub(p.green, 4'd10);
        r.blue  = sat_sub(p.blue, 4'd10);
      end
      OP_CONTR_U: begin
        r.red   = contrast(p.red, mid, 1'b1);
        r.green = contrast(p.green, mid, 1'b1);
        r.blue  = contrast(p.blue, mid, 1'b1);
      end
      OP_CONTR_D: begin
        r.red   = contrast(p.red, mid, 1'b0);
        r.green = contrast(p.green, mid, 1'b0);
        r.blue  = contrast(p.blue, mid, 1'b0);
      end
      OP_INVERT: r = ~p;
      OP_SEPIA: begin
        r.green = {1'b0, p.green[7:1]};
        r.blue  = div15(p.blue);
      end
      OP_GRAY: begin
        r.green = p.red;
        r.blue  = p.red;
      end
      OP_R_UP: r.red   = sat_add(p.red, 4'd5);
      OP_G_UP: r.green = sat_add(p.green, 4'd5);
      OP_B_UP: r.blue  = sat_add(p.blue, 4'd5);
      OP_R_DN: r.red   = sat_sub(p.red, 4'd5);
      OP_G_DN: r.green = sat_sub(p.green, 4'd5);
      OP_B_DN: r.blue  = sat_sub(p.blue, 4'd5);
      default: r = p;  // identity and unused codes
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/ccap_front.sv =====
// ---------------------------------------------------------------------------
// ccap_front
// Input register: takes stream requests and pushes pixels into the queue.
// ---------------------------------------------------------------------------
`default_nettype none
module ccap_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [ccap_pkg::PIX_W-1:0] in_tdata,
  input  wire logic                     q_full,
  output logic                          q_push,
  output ccap_pkg::pixel_t              q_push_pix
);

  logic             v_r, v_nxt;
  ccap_pkg::pixel_t pix_r;

  assign in_tready  = !v_r || !q_full;
  assign q_push     = v_r && !q_full;
  assign q_push_pix = pix_r;

  always_comb begin
    v_nxt = v_r;
    if (in_tvalid && in_tready) begin
      v_nxt = 1'b1;
    end else if (q_push) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
    if (in_tvalid && in_tready) begin
      pix_r <= ccap_pkg::pixel_t'(in_tdata);
    end
  end

endmodule
`default_nettype wire

// ===== design/ccap_queue.sv =====
// ---------------------------------------------------------------------------
// ccap_queue
// Short FIFO decoupling the front register from the adjustment chain.
// ---------------------------------------------------------------------------
`default_nettype none
module ccap_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire ccap_pkg::pixel_t push_pix,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output ccap_pkg::pixel_t      head_pix
);
`include "assert_macros.svh"

  localparam int unsigned PTR_W = $clog2(ccap_pkg::QDEPTH);
  localparam int unsigned CNT_W = $clog2(ccap_pkg::QDEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(ccap_pkg::QDEPTH);

  ccap_pkg::pixel_t   mem_r [ccap_pkg::QDEPTH];
  logic [PTR_W-1:0]   wr_r, rd_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == DEPTH_C);
  assign head_valid = (cnt_r != '0);
  assign head_pix   = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
    if (push) begin
      mem_r[wr_r] <= push_pix;
    end
  end

  `CCAP_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= DEPTH_C)
  `CCAP_ASSERT(a_no_push_full, clk, rst_n, !(push && full))
  `CCAP_ASSERT(a_no_pop_empty, clk, rst_n, !(pop && !head_valid))

endmodule
`default_nettype wire

// ===== design/ccap_back.sv =====
// ---------------------------------------------------------------------------
// ccap_back
// Adjustment chain: one registered stage per op, elastic valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none
module ccap_back #(
  parameter int unsigned STAGES = ccap_pkg::STAGES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ccap_pkg::op_t    ops [ccap_pkg::NUM_OPS],
  input  wire logic [7:0]       midpoint,
  input  wire logic             q_valid,
  input  wire ccap_pkg::pixel_t q_pix,
  output logic                  q_take,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ccap_pkg::pixel_t      out_pix
);
`include "assert_macros.svh"

  logic             v_r  [STAGES];
  ccap_pkg::pixel_t pix_r [STAGES];
  logic             rdy  [STAGES+1];

  assign rdy[STAGES] = out_ready;
  assign q_take      = q_valid && rdy[0];
  assign out_valid   = v_r[STAGES-1];
  assign out_pix     = pix_r[STAGES-1];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic             src_v;
    ccap_pkg::pixel_t src_pix;

    if (s == 0) begin : g_first
      assign src_v   = q_valid;
      assign src_pix = q_pix;
    end else begin : g_next
      assign src_v   = v_r[s-1];
      assign src_pix = pix_r[s-1];
    end

    // stage moves when empty or when the next one takes its pixel
    assign rdy[s] = !v_r[s] || rdy[s+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= src_v;
      end
      if (rdy[s]) begin
        pix_r[s] <= ccap_pkg::apply_op(ops[s], midpoint, src_pix);
      end
    end
  end

  `CCAP_ASSERT_NEXT(a_stall_hold, clk, rst_n, v_r[0] && !rdy[1],
                    v_r[0] && $stable(pix_r[0]))
  `CCAP_ASSERT_NEXT(a_take_lands, clk, rst_n, q_take, v_r[0])

endmodule
`default_nettype wire

// ===== design/cascaded_color_adjust_pipeline_core.sv =====
// Path to out_tvalid: the front reg loads on the input request edge, then the queue
// write, then one reg per stage.
// Throughput: one pixel per cycle while out_tready is high; each op is computed into its stage register.
// The four-entry queue lets the front keep taking pixels while the chain is stalled.
// Reset (rst_n low, synchronous): all valids and queue pointers clear, every stage op
// returns to identity and the contrast midpoint to 128. No clearing pass.
// ---------------------------------------------------------------------------
// cascaded_color_adjust_pipeline_core
// RGB pixel stream through a configurable chain of colour adjustment stages.
// ---------------------------------------------------------------------------
`default_nettype none
module cascaded_color_adjust_pipeline_core #(
  parameter int unsigned STAGES = ccap_pkg::STAGES_DEF   // 1 .. 6
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // pixel input
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [ccap_pkg::PIX_W-1:0]       in_tdata,   // red_in, green_in, blue_in
  // adjusted pixel output
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [ccap_pkg::PIX_W-1:0]            out_tdata,  // red_out, green_out, blue_out
  // register writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ccap_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ccap_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // -------------------------------------------------------------------------
  // Register map: indexes 0..5 are stage ops, 6 is the contrast midpoint.
  // Index 7 is accepted and dropped. Ops of stages at or beyond STAGES are
  // still writable but never used.
  // -------------------------------------------------------------------------
  ccap_pkg::op_t ops_r [ccap_pkg::NUM_OPS];
  logic [7:0]    mid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ccap_pkg::NUM_OPS; i++) begin
        ops_r[i] <= ccap_pkg::OP_IDENT;
      end
      mid_r <= ccap_pkg::MIDPOINT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index < ccap_pkg::REG_MIDPOINT) begin
        ops_r[cfg_index] <= ccap_pkg::op_t'(cfg_data[3:0]);
      end else if (cfg_index == ccap_pkg::REG_MIDPOINT) begin
        mid_r <= cfg_data;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Front: input register, pushes into the queue when there is room.
  // -------------------------------------------------------------------------
  logic             q_full;
  logic             q_push;
  ccap_pkg::pixel_t q_push_pix;

  ccap_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_push_pix (q_push_pix)
  );

  // -------------------------------------------------------------------------
  // Queue between front and adjustment chain.
  // -------------------------------------------------------------------------
  logic             q_head_valid;
  ccap_pkg::pixel_t q_head_pix;
  logic             q_take;

  ccap_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_pix   (q_push_pix),
    .full       (q_full),
    .pop        (q_take),
    .head_valid (q_head_valid),
    .head_pix   (q_head_pix)
  );

  // -------------------------------------------------------------------------
  // Back: STAGES registered adjustment stages; the last one is the output
  // register, so results wait there while the chain keeps filling.
  // -------------------------------------------------------------------------
  ccap_pkg::pixel_t out_pix;

  ccap_back #(
    .STAGES (STAGES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ops       (ops_r),
    .midpoint  (mid_r),
    .q_valid   (q_head_valid),
    .q_pix     (q_head_pix),
    .q_take    (q_take),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pix   (out_pix)
  );

  assign out_tdata = out_pix;

endmodule
`default_nettype wire
